### rtl/afsm_pkg.sv
// Shared types, codes and widths for the arming and flight-state sequencer.
// No dependencies; imported by every module of the block.
package afsm_pkg;

	localparam int STICK_BITS = 11;
	// comparison width: holds stick values and config sums such as stick_max + dead_band
	localparam int CMP_W = ((STICK_BITS > 12) ? STICK_BITS : 12) + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STICK_MAX = 2'd0,
		CFG_STICK_MIN = 2'd1,
		CFG_DEAD_BAND = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT   = 3'd0,
		ST_CAL    = 3'd1,
		ST_READY  = 3'd2,
		ST_IDLE   = 3'd3,
		ST_HOVER  = 3'd4,
		ST_MOVING = 3'd5
	} fstate_t;

	localparam logic       ACT_FRAME = 1'b0;
	localparam logic       ACT_FORCE = 1'b1;

	localparam logic [1:0] SW_UP   = 2'd0;
	localparam logic [1:0] SW_DOWN = 2'd2;

	localparam logic [1:0] LED_NONE  = 2'd0;
	localparam logic [1:0] LED_RED   = 2'd1;
	localparam logic [1:0] LED_GREEN = 2'd2;

	localparam logic [2:0] PAT_NONE  = 3'd0;
	localparam logic [2:0] PAT_ARMED = 3'd0;
	localparam logic [2:0] PAT_FLY   = 3'd2;
	localparam logic [2:0] PAT_STOP  = 3'd5;

	localparam logic [1:0] DRV_OFF  = 2'd0;
	localparam logic [1:0] DRV_IDLE = 2'd1;
	localparam logic [1:0] DRV_FLY  = 2'd2;

	typedef struct packed {
		logic [9:0]  stick_max;
		logic [10:0] stick_min;
		logic [9:0]  dead_band;
	} cfg_t;

	typedef struct packed {
		logic                  action;
		logic [1:0]            left_switch;
		logic [1:0]            right_switch;
		logic [STICK_BITS-1:0] stick_a;
		logic [STICK_BITS-1:0] stick_b;
		logic [STICK_BITS-1:0] stick_c;
		logic [STICK_BITS-1:0] stick_throttle;
		logic [2:0]            requested_state;
	} item_t;

	typedef struct packed {
		logic       armed;
		fstate_t    flight_state;
		logic       led_write;
		logic [1:0] led_color;
		logic [2:0] led_pattern;
		logic [1:0] motor_drive;
	} result_t;

endpackage

### rtl/arming_flight_state_machine.sv
// Arming and flight-state sequencer, top level. Depends on afsm_pkg, afsm_cfg, afsm_decide.
// Pipeline: input register, then the decision into the result register. Throughput: one
// item per cycle while out_stall does not hold the result register; the decision reads the
// mode and state registers written by the previous item in the same cycle.
// Reset: asynchronous, clears the pipeline, mode to stop, state to init, config to defaults.
module arming_flight_state_machine import afsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [1:0]            left_switch,
	input  logic [1:0]            right_switch,
	input  logic [STICK_BITS-1:0] stick_a,
	input  logic [STICK_BITS-1:0] stick_b,
	input  logic [STICK_BITS-1:0] stick_c,
	input  logic [STICK_BITS-1:0] stick_throttle,
	input  logic [2:0]            requested_state,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  armed,
	output logic [2:0]            flight_state,
	output logic                  led_write,
	output logic [1:0]            led_color,
	output logic [2:0]            led_pattern,
	output logic [1:0]            motor_drive
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    mode_q;
	fstate_t state_q;
	result_t res, res_q;
	logic    out_valid_q;
	logic    adv;

	afsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	afsm_decide u_decide (
		.item  (item_s1),
		.mode  (mode_q),
		.state (state_q),
		.cfg   (cfg),
		.res   (res)
	);

	// result register free or being drained this cycle
	assign adv      = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
			state_q     <= ST_INIT;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv)
				out_valid_q <= valid_s1;
			if (valid_s1 && adv) begin
				mode_q  <= res.armed;
				state_q <= res.flight_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action          <= action;
			item_s1.left_switch     <= left_switch;
			item_s1.right_switch    <= right_switch;
			item_s1.stick_a         <= stick_a;
			item_s1.stick_b         <= stick_b;
			item_s1.stick_c         <= stick_c;
			item_s1.stick_throttle  <= stick_throttle;
			item_s1.requested_state <= requested_state;
		end
		if (valid_s1 && adv)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign armed        = res_q.armed;
	assign flight_state = res_q.flight_state;
	assign led_write    = res_q.led_write;
	assign led_color    = res_q.led_color;
	assign led_pattern  = res_q.led_pattern;
	assign motor_drive  = res_q.motor_drive;

endmodule

### rtl/afsm_cfg.sv
// Configuration registers: stick full-scale limits and dead band.
// Depends on afsm_pkg.
module afsm_cfg import afsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	localparam logic [9:0]  STICK_MAX_RST = 10'd660;
	localparam logic [10:0] STICK_MIN_RST = 11'h56C; // -660
	localparam logic [9:0]  DEAD_BAND_RST = 10'd50;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_max <= STICK_MAX_RST;
			cfg_q.stick_min <= STICK_MIN_RST;
			cfg_q.dead_band <= DEAD_BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STICK_MAX: cfg_q.stick_max <= cfg_data[9:0];
				CFG_STICK_MIN: cfg_q.stick_min <= cfg_data;
				CFG_DEAD_BAND: cfg_q.dead_band <= cfg_data[9:0];
				default: ; // unmapped index
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/afsm_decide.sv
// Next-state, LED and drive-class decision for one item against the held mode and state.
// Depends on afsm_pkg; purely combinational.
module afsm_decide import afsm_pkg::*; (
	input  item_t   item,
	input  logic    mode,
	input  fstate_t state,
	input  cfg_t    cfg,
	output result_t res
);

	logic signed [CMP_W-1:0] a_w, b_w, c_w, t_w;
	logic signed [CMP_W-1:0] smax_w, smin_w, db_w, ndb_w;
	logic signed [CMP_W-1:0] max_hi, max_lo, min_hi;
	logic gesture, thr_up, any_off, all_centred;
	logic    mode_n;
	fstate_t state_n;

	function automatic logic centred(input logic signed [CMP_W-1:0] c,
			input logic signed [CMP_W-1:0] db, input logic signed [CMP_W-1:0] ndb);
		centred = (c <= db) && (c > ndb);
	endfunction

	function automatic logic off_centre(input logic signed [CMP_W-1:0] c,
			input logic signed [CMP_W-1:0] db, input logic signed [CMP_W-1:0] ndb);
		off_centre = (c >= db) || (c <= ndb);
	endfunction

	always_comb begin
		a_w    = CMP_W'($signed(item.stick_a));
		b_w    = CMP_W'($signed(item.stick_b));
		c_w    = CMP_W'($signed(item.stick_c));
		t_w    = CMP_W'($signed(item.stick_throttle));
		smax_w = $signed(CMP_W'(cfg.stick_max));
		smin_w = CMP_W'($signed(cfg.stick_min));
		db_w   = $signed(CMP_W'(cfg.dead_band));
		ndb_w  = -db_w;
		max_hi = smax_w + db_w;
		max_lo = smax_w - db_w;
		min_hi = smin_w + db_w;

		gesture     = (a_w <= max_hi) && (b_w <= min_hi) && (c_w >= max_lo) && (t_w <= min_hi);
		thr_up      = (t_w >= db_w);
		any_off     = off_centre(a_w, db_w, ndb_w) || off_centre(b_w, db_w, ndb_w) ||
		              off_centre(c_w, db_w, ndb_w) || off_centre(t_w, db_w, ndb_w);
		all_centred = centred(a_w, db_w, ndb_w) && centred(b_w, db_w, ndb_w) &&
		              centred(c_w, db_w, ndb_w) && centred(t_w, db_w, ndb_w);

		mode_n          = mode;
		state_n         = state;
		res.led_write   = 1'b0;
		res.led_color   = LED_NONE;
		res.led_pattern = PAT_NONE;

		if (item.action == ACT_FORCE) begin
			if (!mode && item.requested_state <= 3'(ST_MOVING))
				state_n = fstate_t'(item.requested_state);
		end else if (item.left_switch == SW_UP) begin
			mode_n = 1'b0;
			if (state == ST_IDLE || state == ST_HOVER || state == ST_MOVING) begin
				res.led_write   = 1'b1;
				res.led_color   = LED_RED;
				res.led_pattern = PAT_STOP;
				state_n         = ST_READY;
			end
			// calibration overrides, red LED still reported
			if (item.right_switch == SW_DOWN)
				state_n = ST_CAL;
		end else if (item.left_switch == SW_DOWN) begin
			if (!mode) begin
				if (state == ST_READY)
					mode_n = 1'b1;
			end else begin
				unique case (state)
					ST_READY: if (gesture) begin
						res.led_write   = 1'b1;
						res.led_color   = LED_GREEN;
						res.led_pattern = PAT_ARMED;
						state_n         = ST_IDLE;
					end
					ST_IDLE: if (thr_up) begin
						res.led_write   = 1'b1;
						res.led_color   = LED_GREEN;
						res.led_pattern = PAT_FLY;
						state_n         = ST_MOVING;
					end
					ST_HOVER: if (any_off) begin
						res.led_write   = 1'b1;
						res.led_color   = LED_GREEN;
						res.led_pattern = PAT_FLY;
						state_n         = ST_MOVING;
					end
					ST_MOVING: if (all_centred) begin
						res.led_write   = 1'b1;
						res.led_color   = LED_GREEN;
						res.led_pattern = PAT_FLY;
						state_n         = ST_HOVER;
					end
					default: ;
				endcase
			end
		end

		res.motor_drive = DRV_OFF;
		if (mode_n) begin
			if (state_n == ST_IDLE)
				res.motor_drive = DRV_IDLE;
			else if (state_n == ST_HOVER || state_n == ST_MOVING)
				res.motor_drive = DRV_FLY;
		end
		res.armed        = mode_n;
		res.flight_state = state_n;
	end

endmodule

### rtl/afsm_checker.sv
// Port-level checks for the sequencer, attached to the top level by bind.
// Depends on afsm_pkg and arming_flight_state_machine.
module afsm_checker import afsm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  action,
	input logic [1:0]            left_switch,
	input logic [1:0]            right_switch,
	input logic [STICK_BITS-1:0] stick_a,
	input logic [STICK_BITS-1:0] stick_b,
	input logic [STICK_BITS-1:0] stick_c,
	input logic [STICK_BITS-1:0] stick_throttle,
	input logic [2:0]            requested_state,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  armed,
	input logic [2:0]            flight_state,
	input logic                  led_write,
	input logic [1:0]            led_color,
	input logic [2:0]            led_pattern,
	input logic [1:0]            motor_drive
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(flight_state) && $stable(armed) &&
		$stable(led_write) && $stable(led_color) && $stable(led_pattern) &&
		$stable(motor_drive))
		else $error("stalled result changed");

	// an input transfer is followed by a valid result once it has passed the input and result registers
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("transfer lost in pipeline");

	// arming only from ready, and running never leaves the flying states
	a_armed_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && armed |-> flight_state == 3'(ST_READY) || flight_state == 3'(ST_IDLE) ||
		flight_state == 3'(ST_HOVER) || flight_state == 3'(ST_MOVING))
		else $error("armed outside flying states");

	a_stop_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !armed |-> motor_drive == DRV_OFF)
		else $error("motors driven while stopped");

	a_led_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !led_write |-> led_color == LED_NONE && led_pattern == PAT_NONE)
		else $error("LED fields set without command");

endmodule

bind arming_flight_state_machine afsm_checker u_afsm_checker (.*);

### tb/arming_flight_state_machine_tb.sv
// Self-checking testbench for the arming and flight-state sequencer.
// Depends on afsm_pkg and arming_flight_state_machine. Directed table first, then
// random flight sequences over several register settings, checked by a local predictor.
`timescale 1ns / 100ps

module arming_flight_state_machine_tb;
	import afsm_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int STICK_HI    = 1023;
	localparam int STICK_LO    = -1024;

	typedef struct packed {
		logic       armed;
		logic [2:0] fstate;
		logic       led_write;
		logic [1:0] led_color;
		logic [2:0] led_pattern;
		logic [1:0] motor_drive;
	} flight_out_t;

	typedef struct packed {
		item_t       stim;
		logic        typed;
		flight_out_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	item_t                 stim_bus = '0;
	logic                  row_typed = 1'b0;
	flight_out_t           row_want = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  armed;
	logic [2:0]            flight_state;
	logic                  led_write;
	logic [1:0]            led_color;
	logic [2:0]            led_pattern;
	logic [1:0]            motor_drive;

	// predictor state and its copy of the registers
	logic        seq_armed = 1'b0;
	fstate_t     seq_state = ST_INIT;
	logic [9:0]  seq_max = 10'd660;
	logic [10:0] seq_min = -11'sd660;
	logic [9:0]  seq_band = 10'd50;

	// settings used to shape the stimulus of the current phase
	int phase_max = 660;
	int phase_min = -660;
	int phase_band = 50;

	flight_out_t expected_results[$];
	dir_row_t    dir_rows[$];
	int          error_count = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          in_burst = 1'b0;
	bit          out_burst = 1'b0;

	always #6 clk = ~clk;

	arming_flight_state_machine i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (stim_bus.action),
		.left_switch     (stim_bus.left_switch),
		.right_switch    (stim_bus.right_switch),
		.stick_a         (stim_bus.stick_a),
		.stick_b         (stim_bus.stick_b),
		.stick_c         (stim_bus.stick_c),
		.stick_throttle  (stim_bus.stick_throttle),
		.requested_state (stim_bus.requested_state),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.armed           (armed),
		.flight_state    (flight_state),
		.led_write       (led_write),
		.led_color       (led_color),
		.led_pattern     (led_pattern),
		.motor_drive     (motor_drive)
	);

	function automatic bit is_centred(int c, int db);
		return c <= db && c > -db;
	endfunction

	function automatic bit is_off_centre(int c, int db);
		return c >= db || c <= -db;
	endfunction

	function automatic flight_out_t advance_sequencer(item_t it);
		flight_out_t r;
		int ca, cb, cc, ct, smax, smin, db;
		r    = '0;
		ca   = int'($signed(it.stick_a));
		cb   = int'($signed(it.stick_b));
		cc   = int'($signed(it.stick_c));
		ct   = int'($signed(it.stick_throttle));
		smax = int'(seq_max);
		smin = int'($signed(seq_min));
		db   = int'(seq_band);
		if (it.action == ACT_FORCE) begin
			if (!seq_armed && it.requested_state <= ST_MOVING)
				seq_state = fstate_t'(it.requested_state);
		end else if (it.left_switch == SW_UP) begin
			seq_armed = 1'b0;
			if (seq_state == ST_IDLE || seq_state == ST_HOVER || seq_state == ST_MOVING) begin
				r.led_write   = 1'b1;
				r.led_color   = LED_RED;
				r.led_pattern = PAT_STOP;
				seq_state     = ST_READY;
			end
			// calibration overrides the state but the red command still stands
			if (it.right_switch == SW_DOWN)
				seq_state = ST_CAL;
		end else if (it.left_switch == SW_DOWN) begin
			if (!seq_armed) begin
				if (seq_state == ST_READY)
					seq_armed = 1'b1;
			end else begin
				case (seq_state)
					ST_READY: begin
						if (ca <= smax + db && cb <= smin + db && cc >= smax - db &&
						    ct <= smin + db) begin
							r.led_write   = 1'b1;
							r.led_color   = LED_GREEN;
							r.led_pattern = PAT_ARMED;
							seq_state     = ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (ct >= db) begin
							r.led_write   = 1'b1;
							r.led_color   = LED_GREEN;
							r.led_pattern = PAT_FLY;
							seq_state     = ST_MOVING;
						end
					end
					ST_HOVER: begin
						if (is_off_centre(ca, db) || is_off_centre(cb, db) ||
						    is_off_centre(cc, db) || is_off_centre(ct, db)) begin
							r.led_write   = 1'b1;
							r.led_color   = LED_GREEN;
							r.led_pattern = PAT_FLY;
							seq_state     = ST_MOVING;
						end
					end
					ST_MOVING: begin
						if (is_centred(ca, db) && is_centred(cb, db) &&
						    is_centred(cc, db) && is_centred(ct, db)) begin
							r.led_write   = 1'b1;
							r.led_color   = LED_GREEN;
							r.led_pattern = PAT_FLY;
							seq_state     = ST_HOVER;
						end
					end
					default: ;
				endcase
			end
		end
		r.motor_drive = DRV_OFF;
		if (seq_armed) begin
			if (seq_state == ST_IDLE)
				r.motor_drive = DRV_IDLE;
			else if (seq_state == ST_HOVER || seq_state == ST_MOVING)
				r.motor_drive = DRV_FLY;
		end
		r.armed  = seq_armed;
		r.fstate = seq_state;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// predictor, scoreboard and register shadow all sample on the same edge
	always @(posedge clk) begin
		flight_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_results.pop_front();
					check_field("armed", 4'(armed), 4'(want.armed));
					check_field("flight_state", 4'(flight_state), 4'(want.fstate));
					check_field("led_write", 4'(led_write), 4'(want.led_write));
					check_field("led_color", 4'(led_color), 4'(want.led_color));
					check_field("led_pattern", 4'(led_pattern), 4'(want.led_pattern));
					check_field("motor_drive", 4'(motor_drive), 4'(want.motor_drive));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STICK_MAX: seq_max = cfg_data[9:0];
					CFG_STICK_MIN: seq_min = cfg_data[10:0];
					CFG_DEAD_BAND: seq_band = cfg_data[9:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = advance_sequencer(stim_bus);
				if (row_typed)
					want = row_want;
				expected_results.push_back(want);
			end
		end
	end

	// receiver: after each result transfer, hold off for a drawn number of cycles
	always @(posedge clk) begin
		int  hold;
		hold = stall_left;
		if (arst_n && out_valid && !out_stall) begin
			hold = out_burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0)
				out_burst = !out_burst;
		end
		if (hold > 0) begin
			stall_left = hold - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left = 0;
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("arming_flight_state_machine_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [STICK_BITS-1:0] to_stick(int v);
		return v[STICK_BITS-1:0];
	endfunction

	function automatic int near_value(int centre, int spread);
		int v;
		v = centre - spread + int'($urandom_range(0, 2 * spread));
		if (v > STICK_HI)
			v = STICK_HI;
		if (v < STICK_LO)
			v = STICK_LO;
		return v;
	endfunction

	function automatic item_t make_item(logic act, logic [1:0] lsw, logic [1:0] rsw,
	                                    int a, int b, int c, int t, logic [2:0] req);
		item_t it;
		it.action          = act;
		it.left_switch     = lsw;
		it.right_switch    = rsw;
		it.stick_a         = to_stick(a);
		it.stick_b         = to_stick(b);
		it.stick_c         = to_stick(c);
		it.stick_throttle  = to_stick(t);
		it.requested_state = req;
		return it;
	endfunction

	function automatic flight_out_t result_of(logic arm, fstate_t st, logic lw,
	                                          logic [1:0] lc, logic [2:0] lp,
	                                          logic [1:0] drv);
		flight_out_t r;
		r.armed       = arm;
		r.fstate      = st;
		r.led_write   = lw;
		r.led_color   = lc;
		r.led_pattern = lp;
		r.motor_drive = drv;
		return r;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.action          = 1'($urandom_range(0, 1));
		it.left_switch     = 2'($urandom_range(0, 3));
		it.right_switch    = 2'($urandom_range(0, 3));
		it.stick_a         = STICK_BITS'($urandom);
		it.stick_b         = STICK_BITS'($urandom);
		it.stick_c         = STICK_BITS'($urandom);
		it.stick_throttle  = STICK_BITS'($urandom);
		it.requested_state = 3'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic item_t frame_item(logic [1:0] lsw);
		item_t it;
		it             = random_item();
		it.action      = ACT_FRAME;
		it.left_switch = lsw;
		return it;
	endfunction

	function automatic item_t centred_frame();
		item_t it;
		it                = frame_item(SW_DOWN);
		it.stick_a        = to_stick(near_value(0, phase_band + 2));
		it.stick_b        = to_stick(near_value(0, phase_band + 2));
		it.stick_c        = to_stick(near_value(0, phase_band + 2));
		it.stick_throttle = to_stick(near_value(0, phase_band + 2));
		return it;
	endfunction

	// called on a rising edge; returns on the edge of the transfer
	task automatic drive_item(item_t it, logic typed, flight_out_t want);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 15) == 0)
			in_burst = !in_burst;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stim_bus  <= it;
		row_typed <= typed;
		row_want  <= want;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic send(item_t it);
		drive_item(it, 1'b0, '0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		// let the last transfer be queued before the queue is polled
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// leave a margin for the pipeline to drain
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int smax, int smin, int band);
		phase_max  = smax;
		phase_min  = smin;
		phase_band = band;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STICK_MAX;
		cfg_data  <= {1'($urandom_range(0, 1)), smax[9:0]};
		@(posedge clk);
		cfg_index <= CFG_STICK_MIN;
		cfg_data  <= smin[10:0];
		@(posedge clk);
		cfg_index <= CFG_DEAD_BAND;
		cfg_data  <= {1'($urandom_range(0, 1)), band[9:0]};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop, force ready, arm, gesture, then fly about
	task automatic run_flight_sequence();
		item_t it;
		int    pick, level;
		send(frame_item(SW_UP));
		it = random_item();
		it.action = ACT_FORCE;
		it.requested_state = ST_READY;
		send(it);
		send(frame_item(SW_DOWN));
		repeat ($urandom_range(1, 2)) begin
			it = frame_item(SW_DOWN);
			it.stick_a        = to_stick(near_value(phase_max, phase_band + 8));
			it.stick_b        = to_stick(near_value(phase_min, phase_band + 8));
			it.stick_c        = to_stick(near_value(phase_max, phase_band + 8));
			it.stick_throttle = to_stick(near_value(phase_min, phase_band + 8));
			send(it);
		end
		repeat ($urandom_range(2, 10)) begin
			pick = $urandom_range(0, 9);
			if (pick <= 2) begin
				it = frame_item(SW_DOWN);
				it.stick_throttle = to_stick(near_value(phase_band, 4));
			end else if (pick <= 7) begin
				it = centred_frame();
				if (pick >= 6) begin
					level = near_value($urandom_range(0, 1) ? phase_band : -phase_band, 2);
					case ($urandom_range(0, 3))
						0: it.stick_a = to_stick(level);
						1: it.stick_b = to_stick(level);
						2: it.stick_c = to_stick(level);
						default: it.stick_throttle = to_stick(level);
					endcase
				end
			end else if (pick == 8) begin
				it = frame_item(2'($urandom_range(0, 1) ? 1 : 3));
			end else begin
				it = random_item();
			end
			send(it);
		end
		if ($urandom_range(0, 1))
			send(frame_item(SW_UP));
	endtask

	initial begin
		dir_row_t row;
		int       target;
		// directed rows at reset settings: max 660, min -660, band 50
		dir_rows.push_back({make_item(ACT_FRAME, 2'd1, SW_UP, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(0, ST_INIT, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, 2'd3, 2'd3, STICK_HI, STICK_HI, STICK_HI,
		                    STICK_HI, 3'd7), 1'b1,
		                    result_of(0, ST_INIT, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_DOWN, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(0, ST_INIT, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FORCE, SW_UP, SW_UP, 0, 0, 0, 0, 3'd6), 1'b1,
		                    result_of(0, ST_INIT, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FORCE, 2'd3, 2'd3, STICK_HI, STICK_HI, STICK_HI,
		                    STICK_HI, 3'd7), 1'b1,
		                    result_of(0, ST_INIT, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FORCE, SW_DOWN, SW_UP, 0, 0, 0, 0, ST_CAL), 1'b1,
		                    result_of(0, ST_CAL, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FORCE, SW_UP, SW_DOWN, STICK_LO, STICK_LO,
		                    STICK_LO, STICK_LO, ST_HOVER), 1'b0, flight_out_t'(0)});
		// switch up from a flying state: red stop command, back to ready
		dir_rows.push_back({make_item(ACT_FRAME, SW_UP, SW_UP, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(0, ST_READY, 1, LED_RED, PAT_STOP, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(1, ST_READY, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		// forced request while running is ignored
		dir_rows.push_back({make_item(ACT_FORCE, SW_DOWN, SW_UP, 0, 0, 0, 0, ST_MOVING), 1'b1,
		                    result_of(1, ST_READY, 0, LED_NONE, PAT_NONE, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 711, -610, 610, -610, 3'd0),
		                    1'b0, flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 710, -610, 610, -610, 3'd0),
		                    1'b0, flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 0, 0, 0, 49, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 0, 0, 0, 50, 3'd0), 1'b1,
		                    result_of(1, ST_MOVING, 1, LED_GREEN, PAT_FLY, DRV_FLY)});
		// centred is -band < c <= band
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 50, -49, 0, -50, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 50, -49, 0, 0, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 49, -49, 49, -49, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, 0, 0, -50, 0, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		// emergency stop and calibration in one frame
		dir_rows.push_back({make_item(ACT_FRAME, SW_UP, SW_DOWN, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(0, ST_CAL, 1, LED_RED, PAT_STOP, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_UP, SW_DOWN, 0, 0, 0, 0, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FORCE, SW_UP, SW_UP, 0, 0, 0, 0, ST_READY), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, 2'd1, 0, 0, 0, 0, 3'd0), 1'b0,
		                    flight_out_t'(0)});
		dir_rows.push_back({make_item(ACT_FRAME, SW_DOWN, SW_UP, STICK_LO, STICK_LO, STICK_HI,
		                    STICK_LO, 3'd0), 1'b1,
		                    result_of(1, ST_IDLE, 1, LED_GREEN, PAT_ARMED, DRV_IDLE)});
		// second switch code 3 is not down: no calibration
		dir_rows.push_back({make_item(ACT_FRAME, SW_UP, 2'd3, 0, 0, 0, 0, 3'd0), 1'b1,
		                    result_of(0, ST_READY, 1, LED_RED, PAT_STOP, DRV_OFF)});
		dir_rows.push_back({make_item(ACT_FRAME, 2'd1, SW_DOWN, STICK_LO, STICK_LO, STICK_LO,
		                    STICK_LO, 3'd0), 1'b0, flight_out_t'(0)});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			drive_item(row.stim, row.typed, row.want);
		end
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_config(STICK_HI, STICK_LO, 1023);
				1: set_config(0, 0, 0);
				2: set_config(660, -660, 50);
				3: set_config(STICK_HI, STICK_LO, 0);
				default: set_config($urandom_range(300, 1023), -int'($urandom_range(300, 1024)),
				                    $urandom_range(0, 120));
			endcase
			target = items_sent + 65;
			while (items_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4)) send(random_item());
				else
					run_flight_sequence();
			end
			wait_idle();
		end

		if (error_count == 0)
			$display("arming_flight_state_machine_tb: done, clean");
		else
			$display("arming_flight_state_machine_tb: done, errors");
		$finish;
	end

endmodule
